@@ rtl/core/u8cp_pkg.sv @@
// Shared types, constants and the code point to CP437 glyph table.
package u8cp_pkg;

   localparam int ByteWidth  = 8;
   localparam int PointWidth = 16;
   localparam int PendWidth  = 2;

   localparam int MapLen            = 63;
   localparam int MapEntriesDefault = 63;

   localparam logic [ByteWidth-1:0]  SubChar    = 8'h3F;  // '?'
   localparam logic [PointWidth-1:0] AsciiLimit = 16'd128;

   // lead byte classes
   localparam logic [7:0] AsciiMask  = 8'h80;
   localparam logic [7:0] Lead2Mask  = 8'hE0;
   localparam logic [7:0] Lead2Code  = 8'hC0;
   localparam logic [7:0] Lead3Mask  = 8'hF0;
   localparam logic [7:0] Lead3Code  = 8'hE0;
   localparam logic [7:0] Lead2Bits  = 8'h1F;
   localparam logic [7:0] Lead3Bits  = 8'h0F;
   localparam logic [7:0] ContBits   = 8'h3F;

   localparam logic [PendWidth-1:0] PendNone = 2'd0;
   localparam logic [PendWidth-1:0] PendOne  = 2'd1;
   localparam logic [PendWidth-1:0] PendTwo  = 2'd2;

   typedef struct packed {
      logic [PointWidth-1:0] point;
      logic [ByteWidth-1:0]  glyph;
   } map_pair_type;

   // what the decoder hands on for one byte
   typedef struct packed {
      logic                  emit;     // a result comes out of this byte
      logic                  invalid;  // bad lead byte, forced '?'
      logic [PointWidth-1:0] point;
   } decode_type;

   typedef struct packed {
      logic [ByteWidth-1:0] glyph;
      logic                 unmapped;  // point of 128 or more with no table entry
   } map_result_type;

   localparam map_pair_type GlyphMap [MapLen] = '{
      '{16'h2588, 8'hDB}, '{16'h2593, 8'hDC}, '{16'h2592, 8'hB1}, '{16'h2591, 8'hB0},
      '{16'h25A0, 8'hFE}, '{16'h25A1, 8'hDB}, '{16'h25C6, 8'h04}, '{16'h25CB, 8'h09},
      '{16'h25CF, 8'h0A}, '{16'h2500, 8'hC4}, '{16'h2502, 8'hB3}, '{16'h250C, 8'hDA},
      '{16'h2510, 8'hBF}, '{16'h2514, 8'hC0}, '{16'h2518, 8'hD9}, '{16'h251C, 8'hC3},
      '{16'h2524, 8'hB4}, '{16'h252C, 8'hC2}, '{16'h2534, 8'hC1}, '{16'h253C, 8'hC5},
      '{16'h2550, 8'hCD}, '{16'h2551, 8'hBA}, '{16'h2554, 8'hC9}, '{16'h2557, 8'hBB},
      '{16'h255A, 8'hC8}, '{16'h255D, 8'hBC}, '{16'h2560, 8'hCC}, '{16'h2563, 8'hB9},
      '{16'h2566, 8'hCB}, '{16'h2569, 8'hCA}, '{16'h256C, 8'hCE}, '{16'h2190, 8'h1B},
      '{16'h2191, 8'h18}, '{16'h2192, 8'h1A}, '{16'h2193, 8'h19}, '{16'h2194, 8'h1D},
      '{16'h2195, 8'h12}, '{16'h21A8, 8'h17}, '{16'h2665, 8'h03}, '{16'h2666, 8'h04},
      '{16'h2663, 8'h05}, '{16'h2660, 8'h06}, '{16'h266A, 8'h0D}, '{16'h266B, 8'h0E},
      '{16'h2319, 8'hF9}, '{16'h2302, 8'h7F}, '{16'h2219, 8'hF9}, '{16'h221A, 8'hFB},
      '{16'h2248, 8'hF7}, '{16'h2264, 8'hF3}, '{16'h2265, 8'hF2}, '{16'h00B0, 8'hF8},
      '{16'h00B1, 8'hF1}, '{16'h00B2, 8'hFD}, '{16'h00B7, 8'hFA}, '{16'h00F7, 8'hF6},
      '{16'h256D, 8'hD5}, '{16'h256E, 8'hB6}, '{16'h256F, 8'hB7}, '{16'h2570, 8'hD6},
      '{16'h2571, 8'hD7}, '{16'h2572, 8'hD8}, '{16'h2573, 8'hD9}
   };

endpackage

@@ rtl/core/u8cp_decode.sv @@
// UTF-8 sequence decoder: pending count, gathered code point bits, emit decision.
module u8cp_decode (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,    // byte in data_byte is consumed
   input  logic [u8cp_pkg::ByteWidth-1:0]     data_byte,
   output u8cp_pkg::decode_type               dec
);
   import u8cp_pkg::*;

   logic [PendWidth-1:0]  pending_ff, pending_in;
   logic [PointWidth-1:0] partial_ff, partial_in;

   always_comb begin
      pending_in  = pending_ff;
      partial_in  = partial_ff;
      dec.emit    = 1'b0;
      dec.invalid = 1'b0;
      dec.point   = {{(PointWidth-ByteWidth){1'b0}}, data_byte};
      if (pending_ff != PendNone) begin
         // continuation: top bits are not checked
         partial_in = {partial_ff[PointWidth-7:0], data_byte[5:0]};
         pending_in = pending_ff - PendOne;
         dec.point  = partial_in;
         dec.emit   = (pending_ff == PendOne);
      end else if ((data_byte & AsciiMask) == 8'h00) begin
         dec.emit = 1'b1;
      end else if ((data_byte & Lead2Mask) == Lead2Code) begin
         partial_in = {{(PointWidth-ByteWidth){1'b0}}, data_byte & Lead2Bits};
         pending_in = PendOne;
      end else if ((data_byte & Lead3Mask) == Lead3Code) begin
         partial_in = {{(PointWidth-ByteWidth){1'b0}}, data_byte & Lead3Bits};
         pending_in = PendTwo;
      end else begin
         dec.emit    = 1'b1;
         dec.invalid = 1'b1;
         dec.point   = {{(PointWidth-ByteWidth){1'b0}}, SubChar};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= PendNone;
         partial_ff <= '0;
      end else if (advance) begin
         pending_ff <= pending_in;
         partial_ff <= partial_in;
      end
   end

   // a sequence never expects more than two more bytes
   assert property (@(posedge clock) disable iff (reset) pending_ff != 2'd3)
      else $error("pending count out of range");

   // an open sequence counts down by one per consumed byte
   assert property (@(posedge clock) disable iff (reset)
      advance && pending_ff != PendNone |=> pending_ff == $past(pending_ff) - PendOne)
      else $error("pending count did not step down");

   // nothing is emitted while more continuation bytes are due
   assert property (@(posedge clock) disable iff (reset)
      pending_ff == PendTwo |-> !dec.emit)
      else $error("emit in the middle of a sequence");

endmodule

@@ rtl/core/u8cp_glyph_map.sv @@
// Parallel match of a code point against the glyph table, ASCII pass-through.
module u8cp_glyph_map #(
   parameter int MAP_ENTRIES = u8cp_pkg::MapEntriesDefault
) (
   input  logic [u8cp_pkg::PointWidth-1:0] code_point,
   output u8cp_pkg::map_result_type        res
);
   import u8cp_pkg::*;

   logic                 hit;
   logic [ByteWidth-1:0] hit_glyph;

   // walk from the back so the first matching entry wins
   always_comb begin
      hit       = 1'b0;
      hit_glyph = GlyphMap[0].glyph;
      for (int i = MapLen - 1; i >= 0; i--) begin
         if (i < MAP_ENTRIES && GlyphMap[i].point == code_point) begin
            hit       = 1'b1;
            hit_glyph = GlyphMap[i].glyph;
         end
      end
   end

   always_comb begin
      if (hit) begin
         res.glyph    = hit_glyph;
         res.unmapped = 1'b0;
      end else if (code_point < AsciiLimit) begin
         res.glyph    = code_point[ByteWidth-1:0];
         res.unmapped = 1'b0;
      end else begin
         res.glyph    = SubChar;
         res.unmapped = 1'b1;
      end
   end

endmodule

@@ rtl/core/utf8_to_cp437_stream_decoder_unit.sv @@
// UTF-8 to CP437 stream decoder: input register, decode and table match, result register.
//
// Takes one UTF-8 byte per word on req_ and gives one CP437 word on rsp_ for
// each completed code point (one, two or three byte sequences; a bad lead byte
// gives '?' at once with tuser set). Sustained rate is one byte per clock while
// rsp_ is not back-pressured; the word for a completing byte goes from the input
// register through the single decode-and-match pass into the result register,
// and waits in either register while rsp_tready is low.
// Continuation bytes are not checked and overlong forms are passed through.
module utf8_to_cp437_stream_decoder_unit #(
   parameter int MAP_ENTRIES = u8cp_pkg::MapEntriesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] glyph, [23:8] code_point
   output logic        rsp_tuser    // [0] substituted
);
   import u8cp_pkg::*;

   logic                  in_vld_ff, in_vld_in;
   logic [ByteWidth-1:0]  in_byte_ff;
   logic                  out_vld_ff, out_vld_in;
   logic [ByteWidth-1:0]  out_glyph_ff;
   logic [PointWidth-1:0] out_point_ff;
   logic                  out_sub_ff;

   logic           out_free;
   logic           advance;
   decode_type     dec;
   map_result_type map_res;

   assign out_free   = !out_vld_ff || rsp_tready;
   assign advance    = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;

   assign in_vld_in  = req_tvalid ? 1'b1 : (in_vld_ff && !advance);
   assign out_vld_in = advance ? dec.emit : (out_vld_ff && !rsp_tready);

   u8cp_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (in_byte_ff),
      .dec       (dec)
   );

   u8cp_glyph_map #(
      .MAP_ENTRIES (MAP_ENTRIES)
   ) u_glyph_map (
      .code_point (dec.point),
      .res        (map_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= in_vld_in;
         end
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && dec.emit) begin
         out_point_ff <= dec.point;
         out_glyph_ff <= dec.invalid ? SubChar : map_res.glyph;
         out_sub_ff   <= dec.invalid || map_res.unmapped;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_point_ff, out_glyph_ff};
   assign rsp_tuser  = out_sub_ff;

   // a substituted word always carries '?'
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[7:0] == SubChar)
      else $error("substitution without question mark");

   // points below 128 are never substituted unless forced by a bad lead
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[23:8] < AsciiLimit && rsp_tdata[23:8] != 16'h003F
      |-> !rsp_tuser)
      else $error("ascii point substituted");

   // an emitting byte that is consumed shows up as a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      advance && dec.emit |=> rsp_tvalid)
      else $error("decoded word lost");

endmodule
